[hdl/sbcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sub-block change flag grid package
// Shared types, codes and default sizes for the change flag grid.
// ----------------------------------------------------------------------------
package sbcf_pkg;

    // Default sizes
    localparam int MAX_BLOCKS_PER_AXIS_DEF = 15;
    localparam int SUBBLOCKS_PER_AXIS_DEF  = 32;

    // Field widths
    localparam int COORD_W = 4;   // block coordinate and block count
    localparam int SUB_W   = 6;   // sub-block coordinate, up to 2*15+2
    localparam int CFG_W   = 4;   // widest configuration register
    localparam int CFG_IW  = 2;   // configuration register index

    // Flag value after reset
    localparam logic [1:0] FLAG_RESET = 2'b01;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_BLOCKS_X = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BLOCKS_Y = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BLOCKS_Z = 2'd2;

    // Operation codes
    localparam logic MODE_QUERY  = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // Input word
    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] block_x;
        logic [COORD_W-1:0] block_y;
        logic [COORD_W-1:0] block_z;
        logic               shifted;
        logic               changed;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic any_set;
        logic bad_coordinate;
    } out_word_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_FINISH
    } state_t;

endpackage

[hdl/subblock_change_flag_grid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sub-block change flag grid
// 3-D grid of 2-bit change flags; queries and updates a 2x2x2 neighborhood.
// ----------------------------------------------------------------------------
// A word passes through an accept step (ST_IDLE), then a read step
// (ST_READ) and a modify/write-back step (ST_MODIFY) for each of the eight
// sub-blocks of the neighborhood, then a finish step (ST_FINISH) that waits
// while the output register is still full. All eight go through the one
// single-port flag memory, one sub-block at a time. A word with a bad
// coordinate never touches the memory and goes from acceptance straight to
// the finish step. After reset the block sweeps the memory once to set every
// flag to 1 over all SUBBLOCKS_PER_AXIS^3 addresses (32768 at the default
// size); s_ready stays low during the sweep, while configuration writes are
// taken as usual. A finished result sits in an output register, so the next
// word is accepted while it waits for m_ready.
// ----------------------------------------------------------------------------
module subblock_change_flag_grid #(
    parameter int MAX_BLOCKS_PER_AXIS = sbcf_pkg::MAX_BLOCKS_PER_AXIS_DEF,
    parameter int SUBBLOCKS_PER_AXIS  = sbcf_pkg::SUBBLOCKS_PER_AXIS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [sbcf_pkg::CFG_IW-1:0] cfg_index,
    input  logic [sbcf_pkg::CFG_W-1:0]  cfg_data,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  sbcf_pkg::in_word_t          s_data,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output sbcf_pkg::out_word_t         m_data
);
    import sbcf_pkg::*;

    localparam int S     = SUBBLOCKS_PER_AXIS;
    localparam int DEPTH = S * S * S;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [COORD_W-1:0] COUNT_MAX =
        (MAX_BLOCKS_PER_AXIS > 15) ? COORD_W'(15) : COORD_W'(MAX_BLOCKS_PER_AXIS);

    // Flag memory
    logic [1:0] flag_mem [DEPTH];

    state_t             state_reg, state_next;
    logic [COORD_W-1:0] blocks_x_reg, blocks_y_reg, blocks_z_reg;
    logic [COORD_W-1:0] cfg_sat;
    in_word_t           item_reg;
    logic               bad_reg, bad_next;
    logic               any_reg, any_next;
    logic [2:0]         idx_reg, idx_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [1:0]         rd_data_reg;
    logic               out_valid_reg;
    out_word_t          out_data_reg;

    logic               accept;
    logic               mem_rd, mem_we, out_load, idx_adv;
    logic [AW-1:0]      mem_addr;
    logic [1:0]         mem_wdata;
    logic               base;
    logic [SUB_W-1:0]   sx, sy, sz;
    logic [SUB_W-1:0]   ext_x, ext_y, ext_z;
    logic               in_grid;
    logic [AW-1:0]      nb_addr;

    // Saturate written counts to the largest supported count
    assign cfg_sat = (cfg_data > COUNT_MAX) ? COUNT_MAX : cfg_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_x_reg <= COORD_W'(15);
            blocks_y_reg <= COORD_W'(15);
            blocks_z_reg <= COORD_W'(15);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BLOCKS_X: blocks_x_reg <= cfg_sat;
                CFG_BLOCKS_Y: blocks_y_reg <= cfg_sat;
                CFG_BLOCKS_Z: blocks_z_reg <= cfg_sat;
                default: ;
            endcase
        end
    end

    // Neighbor sub-block coordinates for the current step
    assign base = ~item_reg.shifted;
    assign sx = {1'b0, item_reg.block_x, 1'b0} + SUB_W'(base) + SUB_W'(idx_reg[0]);
    assign sy = {1'b0, item_reg.block_y, 1'b0} + SUB_W'(base) + SUB_W'(idx_reg[1]);
    assign sz = {1'b0, item_reg.block_z, 1'b0} + SUB_W'(base) + SUB_W'(idx_reg[2]);

    // Grid extent per axis: 2 * (count + 1)
    assign ext_x = {1'b0, blocks_x_reg, 1'b0} + SUB_W'(2);
    assign ext_y = {1'b0, blocks_y_reg, 1'b0} + SUB_W'(2);
    assign ext_z = {1'b0, blocks_z_reg, 1'b0} + SUB_W'(2);

    // Drop sub-blocks past the grid edge or the store edge
    assign in_grid = (sx < ext_x) && (sy < ext_y) && (sz < ext_z) &&
                     (int'(sx) < S) && (int'(sy) < S) && (int'(sz) < S);
    assign nb_addr = AW'((int'(sz) * S + int'(sy)) * S + int'(sx));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LAST_ADDR) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = bad_next ? ST_FINISH : ST_READ;
                end
            end
            ST_READ:   state_next = ST_MODIFY;
            ST_MODIFY: begin
                state_next = (idx_reg == 3'd7) ? ST_FINISH : ST_READ;
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        mem_rd   = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        idx_adv  = 1'b0;
        case (state_reg)
            ST_CLEAR:  mem_we = 1'b1;
            ST_IDLE:   s_ready = 1'b1;
            ST_READ:   mem_rd = 1'b1;
            ST_MODIFY: begin
                idx_adv = 1'b1;
                mem_we  = (item_reg.mode == MODE_UPDATE) && in_grid;
            end
            ST_FINISH: out_load = !out_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign accept   = s_valid && s_ready;
    assign bad_next = (s_data.block_x > blocks_x_reg) ||
                      (s_data.block_y > blocks_y_reg) ||
                      (s_data.block_z > blocks_z_reg);

    // Memory address and write data
    assign mem_addr = (state_reg == ST_CLEAR) ? clr_reg : nb_addr;
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_wdata = FLAG_RESET;
        end else if (item_reg.shifted) begin
            mem_wdata = {item_reg.changed, rd_data_reg[0]};
        end else begin
            mem_wdata = {rd_data_reg[1], item_reg.changed};
        end
    end

    // Flag memory port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            flag_mem[mem_addr] <= mem_wdata;
        end
        if (mem_rd) begin
            rd_data_reg <= flag_mem[mem_addr];
        end
    end

    // Step counters and query accumulator
    assign clr_next = clr_reg + AW'(1);
    assign idx_next = accept ? 3'd0 : (idx_adv ? idx_reg + 3'd1 : idx_reg);
    always_comb begin
        any_next = any_reg;
        if (accept) begin
            any_next = 1'b0;
        end else if (idx_adv && in_grid && (rd_data_reg != 2'b00)) begin
            any_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        any_reg <= any_next;
        if (accept) begin
            item_reg <= s_data;
            bad_reg  <= bad_next;
        end
        if (out_load) begin
            out_data_reg.bad_coordinate <= bad_reg;
            out_data_reg.any_set <= !bad_reg && (item_reg.mode == MODE_QUERY) && any_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Checks
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("word accepted during clearing sweep");

    a_write_only_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we && state_reg != ST_CLEAR |-> item_reg.mode == MODE_UPDATE && !bad_reg)
        else $error("flag write outside an update");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside the finish step");

    a_bad_has_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_coordinate |-> !m_data.any_set)
        else $error("bad coordinate reported with any_set");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Change flag grid testbench
// Drives query and update words into the sub-block change flag grid under
// several grid sizes and checks every result against the directed table or a
// local flag grid model: a directed table first, then random phases, most with both sides stalling.
// ----------------------------------------------------------------------------
module tb;
    import sbcf_pkg::*;

    localparam int SUB_N           = SUBBLOCKS_PER_AXIS_DEF;
    localparam int MAX_COUNT       = MAX_BLOCKS_PER_AXIS_DEF;
    localparam int GRID_DEPTH      = SUB_N * SUB_N * SUB_N;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 190;
    localparam int DRAIN_CYCLES    = 40;
    // covers the clearing sweep after reset with a wide margin
    localparam int WATCHDOG_LIMIT  = 200000;
    localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic              is_cfg;
        logic [CFG_IW-1:0] reg_idx;
        logic [CFG_W-1:0]  reg_val;
        in_word_t          word;
        logic              typed;
        out_word_t         want;
    } script_row_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_word_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_word_t         m_data;

    // local copy of the flag grid and the block counts
    logic [1:0]        flag_mem [GRID_DEPTH];
    logic [CFG_W-1:0]  cnt_x = 4'd15;
    logic [CFG_W-1:0]  cnt_y = 4'd15;
    logic [CFG_W-1:0]  cnt_z = 4'd15;

    out_word_t         pending_results [$];
    script_row_t       directed_rows [$];
    int                errors     = 0;
    int                idle_count = 0;
    int                ready_hold = 0;
    bit                calm       = 1'b0;

    subblock_change_flag_grid i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < GRID_DEPTH; i++) flag_mem[i] = FLAG_RESET;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Apply a register write to the local counts
    function automatic void count_write(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
        logic [CFG_W-1:0] v;
        v = (int'(val) > MAX_COUNT) ? CFG_W'(MAX_COUNT) : val;
        case (idx)
            CFG_BLOCKS_X: cnt_x = v;
            CFG_BLOCKS_Y: cnt_y = v;
            CFG_BLOCKS_Z: cnt_z = v;
            default: ;
        endcase
    endfunction

    // Query or update the 2x2x2 neighborhood of one word; return its result
    function automatic out_word_t grid_step(in_word_t w);
        out_word_t res;
        int        base;
        int        sx;
        int        sy;
        int        sz;
        int        addr;
        logic [1:0] f;
        res = '0;
        if (w.block_x > cnt_x || w.block_y > cnt_y || w.block_z > cnt_z) begin
            res.bad_coordinate = 1'b1;
            return res;
        end
        base = w.shifted ? 0 : 1;
        for (int dz = 0; dz < 2; dz++) begin
            for (int dy = 0; dy < 2; dy++) begin
                for (int dx = 0; dx < 2; dx++) begin
                    sx = 2 * int'(w.block_x) + base + dx;
                    sy = 2 * int'(w.block_y) + base + dy;
                    sz = 2 * int'(w.block_z) + base + dz;
                    // sub-blocks past the grid edge read as 0 and drop writes
                    if (sx >= 2 * (int'(cnt_x) + 1) || sy >= 2 * (int'(cnt_y) + 1) ||
                        sz >= 2 * (int'(cnt_z) + 1))
                        continue;
                    if (sx >= SUB_N || sy >= SUB_N || sz >= SUB_N)
                        continue;
                    addr = (sz * SUB_N + sy) * SUB_N + sx;
                    f = flag_mem[addr];
                    if (w.mode == MODE_QUERY) begin
                        if (f != 2'b00) res.any_set = 1'b1;
                    end else begin
                        if (w.shifted) f[1] = w.changed;
                        else f[0] = w.changed;
                        flag_mem[addr] = f;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic script_row_t item_row(logic m, logic [CFG_W-1:0] bx,
                                             logic [CFG_W-1:0] by, logic [CFG_W-1:0] bz,
                                             logic sh, logic ch, logic typed,
                                             logic any, logic bad);
        script_row_t r;
        r = '0;
        r.word = in_word_t'{m, bx, by, bz, sh, ch};
        r.typed = typed;
        r.want = out_word_t'{any, bad};
        return r;
    endfunction

    function automatic script_row_t cfg_row(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
        script_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Present one word and hold it until accepted; log its expected result
    task automatic send_word(in_word_t w, logic typed, out_word_t want);
        out_word_t pred;
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        pred = grid_step(w);
        pending_results.push_back(typed ? want : pred);
    endtask

    // Drop valid for a random gap after an accepted word
    task automatic sender_gap();
        int g;
        g = calm ? 0 : pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Wait until every outstanding result has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        count_write(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Stall the result side at random, except in calm phases
    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else begin
            m_ready <= ($urandom_range(0, 9) < 7);
            ready_hold = pick_gap();
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge aclk) begin
        out_word_t want;
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word any_set=%0b bad_coordinate=%0b",
                         $time, m_data.any_set, m_data.bad_coordinate);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.any_set !== want.any_set) begin
                    $display("%0t: any_set mismatch: expected %0b, got %0b",
                             $time, want.any_set, m_data.any_set);
                    errors++;
                end
                if (m_data.bad_coordinate !== want.bad_coordinate) begin
                    $display("%0t: bad_coordinate mismatch: expected %0b, got %0b",
                             $time, want.bad_coordinate, m_data.bad_coordinate);
                    errors++;
                end
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_count = 0;
        else idle_count = idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        script_row_t     row;
        in_word_t        w;
        logic [CFG_W-1:0] cx;
        logic [CFG_W-1:0] cy;
        logic [CFG_W-1:0] cz;

        // Directed table: reset contents, grid corners, bad coordinates,
        // edge clipping, size changes that keep the flags
        directed_rows.push_back(item_row(MODE_QUERY,  0,  0,  0, 0, 0, 1, 1, 0));
        directed_rows.push_back(item_row(MODE_QUERY,  0,  0,  0, 1, 0, 1, 1, 0));
        directed_rows.push_back(item_row(MODE_QUERY, 15, 15, 15, 1, 0, 1, 1, 0));
        directed_rows.push_back(item_row(MODE_UPDATE, 15, 15, 15, 0, 0, 1, 0, 0));
        directed_rows.push_back(item_row(MODE_QUERY, 15, 15, 15, 0, 0, 0, 0, 0));
        directed_rows.push_back(item_row(MODE_UPDATE, 0,  0,  0, 1, 1, 1, 0, 0));
        directed_rows.push_back(item_row(MODE_QUERY,  0,  0,  0, 1, 0, 0, 0, 0));
        directed_rows.push_back(item_row(MODE_UPDATE, 0,  0,  0, 0, 0, 1, 0, 0));
        directed_rows.push_back(item_row(MODE_QUERY,  0,  0,  0, 0, 0, 0, 0, 0));
        directed_rows.push_back(item_row(MODE_UPDATE, 7,  3, 12, 0, 1, 1, 0, 0));
        directed_rows.push_back(item_row(MODE_QUERY,  7,  3, 12, 1, 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(CFG_BLOCKS_X, 3));
        directed_rows.push_back(cfg_row(CFG_BLOCKS_Y, 2));
        directed_rows.push_back(cfg_row(CFG_BLOCKS_Z, 1));
        directed_rows.push_back(cfg_row(CFG_UNUSED, 15));
        directed_rows.push_back(item_row(MODE_QUERY,  4,  0,  0, 0, 0, 1, 0, 1));
        directed_rows.push_back(item_row(MODE_QUERY,  0,  3,  0, 1, 0, 1, 0, 1));
        directed_rows.push_back(item_row(MODE_UPDATE, 0,  0,  2, 0, 1, 1, 0, 1));
        directed_rows.push_back(item_row(MODE_UPDATE, 3,  2,  1, 0, 0, 1, 0, 0));
        directed_rows.push_back(item_row(MODE_QUERY,  3,  2,  1, 0, 0, 0, 0, 0));
        directed_rows.push_back(item_row(MODE_UPDATE, 3,  2,  1, 1, 0, 1, 0, 0));
        directed_rows.push_back(item_row(MODE_QUERY,  3,  2,  1, 1, 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(CFG_BLOCKS_X, 0));
        directed_rows.push_back(cfg_row(CFG_BLOCKS_Y, 0));
        directed_rows.push_back(cfg_row(CFG_BLOCKS_Z, 0));
        directed_rows.push_back(item_row(MODE_QUERY,  1,  0,  0, 0, 0, 1, 0, 1));
        directed_rows.push_back(item_row(MODE_UPDATE, 0,  0,  0, 0, 0, 1, 0, 0));
        directed_rows.push_back(item_row(MODE_QUERY,  0,  0,  0, 0, 0, 0, 0, 0));
        directed_rows.push_back(item_row(MODE_UPDATE, 0,  0,  0, 1, 0, 1, 0, 0));
        directed_rows.push_back(item_row(MODE_QUERY,  0,  0,  0, 1, 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(CFG_BLOCKS_X, 15));
        directed_rows.push_back(cfg_row(CFG_BLOCKS_Y, 15));
        directed_rows.push_back(cfg_row(CFG_BLOCKS_Z, 15));
        directed_rows.push_back(item_row(MODE_QUERY,  0,  0,  0, 0, 0, 0, 0, 0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                drain();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_word(row.word, row.typed, row.want);
                sender_gap();
            end
        end

        // Random phases, each under its own grid size
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin cx = 15; cy = 15; cz = 15; end
                1: begin cx = 0;  cy = 0;  cz = 0;  end
                2: begin cx = 1;  cy = 1;  cz = 1;  end
                default: begin
                    cx = ($urandom_range(0, 3) < 3) ? CFG_W'($urandom_range(0, 3))
                                                    : CFG_W'($urandom_range(0, 15));
                    cy = ($urandom_range(0, 3) < 3) ? CFG_W'($urandom_range(0, 3))
                                                    : CFG_W'($urandom_range(0, 15));
                    cz = ($urandom_range(0, 3) < 3) ? CFG_W'($urandom_range(0, 3))
                                                    : CFG_W'($urandom_range(0, 15));
                end
            endcase
            drain();
            write_reg(CFG_BLOCKS_X, cx);
            write_reg(CFG_BLOCKS_Y, cy);
            write_reg(CFG_BLOCKS_Z, cz);
            write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 15)));
            calm = (p % 3 == 2);
            w = '0;
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                // revisit the last neighborhood often so updates meet queries
                if (i == 0 || $urandom_range(0, 99) >= 40) begin
                    if ($urandom_range(0, 99) < 88) begin
                        w.block_x = COORD_W'($urandom_range(0, cnt_x));
                        w.block_y = COORD_W'($urandom_range(0, cnt_y));
                        w.block_z = COORD_W'($urandom_range(0, cnt_z));
                    end else begin
                        w.block_x = COORD_W'($urandom_range(0, 15));
                        w.block_y = COORD_W'($urandom_range(0, 15));
                        w.block_z = COORD_W'($urandom_range(0, 15));
                    end
                end
                w.mode = $urandom_range(0, 1) ? MODE_UPDATE : MODE_QUERY;
                w.shifted = 1'($urandom_range(0, 1));
                w.changed = ($urandom_range(0, 9) < 6) ? 1'b0 : 1'b1;
                send_word(w, 1'b0, '0);
                sender_gap();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
